[rtl/ip_range_set_table_unit_defines.svh]
// assertion macros used by the rtl engine
`ifndef IP_RANGE_SET_TABLE_UNIT_DEFINES_SVH
`define IP_RANGE_SET_TABLE_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RSTU_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rstu assertion failed");

// implication checked in the cycle after the antecedent
`define RSTU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rstu assertion failed");

`endif

[rtl/rstu_pkg.sv]
`timescale 1ns / 1ps

package rstu_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_FIND  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic               found;
      logic [ADDR_W-1:0]  range_low;
      logic [ADDR_W-1:0]  range_high;
      logic               status;
      logic [COUNT_W-1:0] range_count;
   } result_type;

endpackage

[rtl/rstu_ram.sv]
`timescale 1ns / 1ps

module rstu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rstu_engine.sv]
`timescale 1ns / 1ps
`include "ip_range_set_table_unit_defines.svh"

module rstu_engine #(
   parameter int MAX_RANGES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rstu_pkg::op_type            in_op,
   input  logic [rstu_pkg::ADDR_W-1:0] in_a,
   input  logic [rstu_pkg::ADDR_W-1:0] in_b,
   output logic                        res_valid,
   input  logic                        res_ready,
   output rstu_pkg::result_type        res
);
   import rstu_pkg::*;

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0] res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic              found_ff, found_in, status_ff, status_in;
   logic              started_ff, started_in, absorbed_ff, absorbed_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [CW-1:0]     count_ff, count_in, rd_idx_ff, rd_idx_in, w_ff, w_in;

   logic                ram_we, ram_re, leave;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [2*ADDR_W-1:0] ram_wdata, ram_rdata;
   logic [ADDR_W-1:0]   e_lo, e_hi;

   assign e_lo = ram_rdata[ADDR_W-1:0];
   assign e_hi = ram_rdata[2*ADDR_W-1:ADDR_W];

   rstu_ram #(.WIDTH(2 * ADDR_W), .DEPTH(MAX_RANGES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      res_lo_in   = res_lo_ff;
      res_hi_in   = res_hi_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      started_in  = started_ff;
      absorbed_in = absorbed_ff;
      rd_vld_in   = 1'b0;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      w_in        = w_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = w_ff[AW-1:0];
      ram_raddr   = rd_idx_ff[AW-1:0];
      ram_wdata   = {hi_ff, lo_ff};
      leave       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in       = in_op;
               found_in    = 1'b0;
               status_in   = 1'b0;
               res_lo_in   = '0;
               res_hi_in   = '0;
               started_in  = 1'b0;
               absorbed_in = 1'b0;
               rd_idx_in   = '0;
               w_in        = '0;
               lo_in       = (in_a < in_b) ? in_a : in_b;
               hi_in       = (in_a < in_b) ? in_b : in_a;
               unique case (in_op)
                  OP_ADD:   state_in = S_SCAN;
                  OP_FIND: begin
                     lo_in    = in_a;
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (op_ff == OP_FIND) begin
                  if (e_lo <= lo_ff && lo_ff <= e_hi) begin
                     found_in  = 1'b1;
                     res_lo_in = e_lo;
                     res_hi_in = e_hi;
                     leave     = 1'b1;
                  end
               end else if (!started_ff && e_hi < lo_ff) begin
                  w_in = w_ff + 1'b1;
               end else begin
                  started_in = 1'b1;
                  if (e_lo <= hi_ff) begin
                     absorbed_in = 1'b1;
                     lo_in       = (e_lo < lo_ff) ? e_lo : lo_ff;
                     hi_in       = (e_hi > hi_ff) ? e_hi : hi_ff;
                  end else if (!absorbed_ff && count_ff >= MAX_CNT) begin
                     status_in = 1'b1;
                     leave     = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     w_in   = w_ff + 1'b1;
                     lo_in  = e_lo;
                     hi_in  = e_hi;
                  end
               end
            end else if (rd_idx_ff == count_ff) begin
               leave = 1'b1;
               if (op_ff == OP_ADD) begin
                  if (!absorbed_ff && count_ff >= MAX_CNT) begin
                     status_in = 1'b1;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = w_ff + 1'b1;
                  end
               end
            end
            if (leave) begin
               state_in = S_DONE;
            end else if (rd_idx_ff < count_ff) begin
               ram_re    = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_lo_ff   <= res_lo_in;
      res_hi_ff   <= res_hi_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      started_ff  <= started_in;
      absorbed_ff <= absorbed_in;
      rd_idx_ff   <= rd_idx_in;
      w_ff        <= w_in;
   end

   assign in_ready        = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res.found       = found_ff;
   assign res.range_low   = res_lo_ff;
   assign res.range_high  = res_hi_ff;
   assign res.status      = status_ff;
   assign res.range_count = COUNT_W'(count_ff);

   `RSTU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT)
   `RSTU_ASSERT_IMPL(a_no_rw_clash, clock, reset, ram_we && ram_re, ram_waddr < ram_raddr)
   `RSTU_ASSERT_NEXT(a_read_data, clock, reset, ram_re, rd_vld_ff || state_ff == S_DONE)

endmodule

[rtl/ip_range_set_table_unit.sv]
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                      | tuser
// req     | in  | addr_a, addr_b                          | op
// rsp     | out | range_low, range_high, range_count, pad | found, status
// csr     | -   | none                                    | -
// add: scans the stored ranges, merges overlapping ones into the new range and writes the table back
// find: reads ranges until the hit or the end of the table, clear and unused op: no scan
// the single memory read port walks the table one entry per cycle
// reset empties the table at once, no clearing pass
// a held result stalls the engine; the next request waits for an idle engine

module ip_range_set_table_unit #(
   parameter int MAX_RANGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // addr_a, addr_b
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // range_low, range_high, range_count, zero pad
   output logic [1:0]  rsp_tuser   // found, status
);
   import rstu_pkg::*;

   result_type eng_res, rsp_ff;
   logic       eng_valid, eng_ready, rsp_valid_ff;

   rstu_engine #(.MAX_RANGES(MAX_RANGES)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (op_type'(req_tuser)),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_ready) begin
         rsp_valid_ff <= eng_valid;
      end
      if (eng_ready && eng_valid) begin
         rsp_ff <= eng_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.range_count, rsp_ff.range_high, rsp_ff.range_low};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.found};

endmodule
